/* sv/krr_pkg.sv */
// ----------------------------------------------------------------------------
// krr_pkg
// Shared types and constants of the keyboard rollover report block: the item
// structs of both channels, the command codes and the controller commands.
// ----------------------------------------------------------------------------
package krr_pkg;

  // Number of non-modifier keys that can be held at once.
  localparam int KEY_SLOTS = 6;
  // Number of key slots shown in a report.
  localparam int OUT_SLOTS = 6;
  // Width of the held key counter, wide enough to hold KEY_SLOTS itself.
  localparam int CNT_W     = $clog2(KEY_SLOTS + 1);

  // Command codes of an input item.
  localparam logic [1:0] CMD_DOWN  = 2'd0;
  localparam logic [1:0] CMD_UP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] modifier_mask;
    logic [7:0] key_usage;
  } key_item_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] slot_a;
    logic [7:0] slot_b;
    logic [7:0] slot_c;
    logic [7:0] slot_d;
    logic [7:0] slot_e;
    logic [7:0] slot_f;
    logic [2:0] held_count;
  } report_t;

  // Operation that the controller asks of the datapath.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_MOD,
    OP_CLR_MOD,
    OP_PRESS,
    OP_LIFT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } ctl_t;

endpackage

/* sv/keyboard_rollover_report.sv */
// ----------------------------------------------------------------------------
// keyboard_rollover_report
// Six-key-rollover keyboard report holder: takes key down, key up and
// release-all items and returns the updated boot keyboard report for each.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake              | Item
//   ---------+-----------+------------------------+---------------------------
//   key      | in        | key_valid / key_stall  | cmd, modifier_mask, usage
//   report   | out       | report_valid / stall   | modifier byte, six slots,
//            |           |                        | held count
//
// Every item produces exactly one report. The report of an item is presented
// on the cycle after the item is accepted; while no report is stalled, one item
// can be accepted in every cycle: the slot compare, the removal shift and the
// append are combinational between the key channel and the state registers.
// Reset (rst, synchronous, active high) clears the modifier byte, all slots
// and the held count, and drops any report that was waiting.
// While a report waits under report_stall, key_stall is raised and no item
// is taken; an item is taken in the very cycle the waiting report leaves.
//
// The controller (krr_ctrl) owns the handshake and decodes each item into an
// operation; the datapath (krr_datapath) holds the report state and applies
// that operation. The report shown is the datapath state itself, which only
// changes when an item is accepted.
// ----------------------------------------------------------------------------
module keyboard_rollover_report (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_valid,
  output logic               key_stall,
  input  krr_pkg::key_item_t key_item,
  output logic               report_valid,
  input  logic               report_stall,
  output krr_pkg::report_t   report
);

  krr_pkg::ctl_t ctl;

  krr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .key_valid     (key_valid),
    .cmd           (key_item.cmd),
    .modifier_mask (key_item.modifier_mask),
    .report_stall  (report_stall),
    .key_stall     (key_stall),
    .report_valid  (report_valid),
    .ctl           (ctl)
  );

  krr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .modifier_mask (key_item.modifier_mask),
    .key_usage     (key_item.key_usage),
    .report        (report)
  );

endmodule

/* sv/krr_ctrl.sv */
// ----------------------------------------------------------------------------
// krr_ctrl
// Handshake controller: decides when an item is taken, decodes it into a
// datapath operation and tracks whether a report waits on the output.
// ----------------------------------------------------------------------------
module krr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  input  logic [1:0]        cmd,
  input  logic [7:0]        modifier_mask,
  input  logic              report_stall,
  output logic              key_stall,
  output logic              report_valid,
  output krr_pkg::ctl_t     ctl
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state;
  logic   accept;
  logic   is_mod;

  // A new item may enter whenever the held report leaves in the same cycle.
  assign key_stall    = (state == ST_FULL) && report_stall;
  assign accept       = key_valid && !key_stall;
  assign report_valid = (state == ST_FULL);
  assign is_mod       = (modifier_mask != 8'd0);

  always_comb begin
    ctl.load = accept;
    case (cmd)
      krr_pkg::CMD_DOWN:  ctl.op = is_mod ? krr_pkg::OP_SET_MOD : krr_pkg::OP_PRESS;
      krr_pkg::CMD_UP:    ctl.op = is_mod ? krr_pkg::OP_CLR_MOD : krr_pkg::OP_LIFT;
      krr_pkg::CMD_CLEAR: ctl.op = krr_pkg::OP_CLEAR;
      default:            ctl.op = krr_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      case (state)
        ST_EMPTY: begin
          if (accept) begin
            state <= ST_FULL;
          end
        end
        ST_FULL: begin
          if (!accept && !report_stall) begin
            state <= ST_EMPTY;
          end
        end
        default: state <= ST_EMPTY;
      endcase
    end
  end

endmodule

/* sv/krr_datapath.sv */
// ----------------------------------------------------------------------------
// krr_datapath
// Report state: modifier byte, ordered key slots and held count, updated in
// one step per operation, and the report formed from that state.
// ----------------------------------------------------------------------------
module krr_datapath (
  input  logic              clk,
  input  logic              rst,
  input  krr_pkg::ctl_t     ctl,
  input  logic [7:0]        modifier_mask,
  input  logic [7:0]        key_usage,
  output krr_pkg::report_t  report
);

  logic [7:0]                mods;
  logic [7:0]                mods_next;
  logic [7:0]                slots      [krr_pkg::KEY_SLOTS];
  logic [7:0]                slots_next [krr_pkg::KEY_SLOTS];
  logic [7:0]                slots_up   [krr_pkg::KEY_SLOTS];
  logic [7:0]                shown      [krr_pkg::OUT_SLOTS];
  logic [krr_pkg::CNT_W-1:0] count;
  logic [krr_pkg::CNT_W-1:0] count_next;
  logic [krr_pkg::KEY_SLOTS-1:0] hit;
  logic [krr_pkg::KEY_SLOTS-1:0] from_hit;
  logic                      any_hit;
  logic                      has_room;

  // Slots at or past the held count always read zero, so a removal only has
  // to pull every slot from the first match onward down by one place.
  always_comb begin
    for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
      hit[i] = (krr_pkg::CNT_W'(i) < count) && (slots[i] == key_usage);
      if (i == krr_pkg::KEY_SLOTS - 1) begin
        slots_up[i] = 8'd0;
      end else begin
        slots_up[i] = slots[(i + 1) % krr_pkg::KEY_SLOTS];
      end
    end
    from_hit[0] = hit[0];
    for (int i = 1; i < krr_pkg::KEY_SLOTS; i++) begin
      from_hit[i] = from_hit[i-1] | hit[i];
    end
  end

  assign any_hit  = |hit;
  assign has_room = (count < krr_pkg::CNT_W'(krr_pkg::KEY_SLOTS));

  always_comb begin
    mods_next  = mods;
    count_next = count;
    for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
      slots_next[i] = slots[i];
    end
    case (ctl.op)
      krr_pkg::OP_SET_MOD: mods_next = mods | modifier_mask;
      krr_pkg::OP_CLR_MOD: mods_next = mods & ~modifier_mask;
      krr_pkg::OP_PRESS: begin
        if ((key_usage != 8'd0) && !any_hit && has_room) begin
          for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
            if (krr_pkg::CNT_W'(i) == count) begin
              slots_next[i] = key_usage;
            end
          end
          count_next = count + krr_pkg::CNT_W'(1);
        end
      end
      krr_pkg::OP_LIFT: begin
        if (any_hit) begin
          for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
            if (from_hit[i]) begin
              slots_next[i] = slots_up[i];
            end
          end
          count_next = count - krr_pkg::CNT_W'(1);
        end
      end
      krr_pkg::OP_CLEAR: begin
        mods_next  = 8'd0;
        count_next = '0;
        for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
          slots_next[i] = 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods  <= 8'd0;
      count <= '0;
      for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
        slots[i] <= 8'd0;
      end
    end else if (ctl.load) begin
      mods  <= mods_next;
      count <= count_next;
      for (int i = 0; i < krr_pkg::KEY_SLOTS; i++) begin
        slots[i] <= slots_next[i];
      end
    end
  end

  // The state moves only when an item is taken, which happens only while no
  // report is held back, so the state itself is the report.
  always_comb begin
    for (int k = 0; k < krr_pkg::OUT_SLOTS; k++) begin
      if (k < krr_pkg::KEY_SLOTS) begin
        shown[k] = slots[k % krr_pkg::KEY_SLOTS];
      end else begin
        shown[k] = 8'd0;
      end
    end
    report.modifier_bits = mods;
    report.slot_a        = shown[0];
    report.slot_b        = shown[1];
    report.slot_c        = shown[2];
    report.slot_d        = shown[3];
    report.slot_e        = shown[4];
    report.slot_f        = shown[5];
    report.held_count    = (32'(count) > 32'd7) ? 3'd7 : 3'(count);
  end

endmodule

/* sv/krr_checker.sv */
// ----------------------------------------------------------------------------
// krr_checker
// Port-level checks of the keyboard rollover report block, bound to its top.
// ----------------------------------------------------------------------------
module krr_checker (
  input logic               clk,
  input logic               rst,
  input logic               key_valid,
  input logic               key_stall,
  input krr_pkg::key_item_t key_item,
  input logic               report_valid,
  input logic               report_stall,
  input krr_pkg::report_t   report
);

  logic key_take;

  assign key_take = key_valid && !key_stall;

  // Reset drops any waiting report.
  a_reset_empty: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("report valid after reset");

  // No item may enter while a report is held back.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (report_valid && report_stall) |-> key_stall)
    else $error("item accepted over a stalled report");

  // Every accepted item yields a report on the next cycle.
  a_report_follows: assert property (@(posedge clk) disable iff (rst)
    key_take |=> report_valid)
    else $error("no report after accepted item");

  // Release all empties the report: the modifier byte, the held count and the first and last slots are checked.
  a_clear_report: assert property (@(posedge clk) disable iff (rst)
    (key_take && (key_item.cmd == krr_pkg::CMD_CLEAR)) |=>
      ((report.modifier_bits == 8'd0) && (report.held_count == 3'd0) &&
       (report.slot_a == 8'd0) && (report.slot_f == 8'd0)))
    else $error("report not empty after release all");

endmodule

bind keyboard_rollover_report krr_checker u_krr_checker (
  .clk          (clk),
  .rst          (rst),
  .key_valid    (key_valid),
  .key_stall    (key_stall),
  .key_item     (key_item),
  .report_valid (report_valid),
  .report_stall (report_stall),
  .report       (report)
);
